@@ src/bisc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bisc_pkg
// Shared types and constants of the bilinear interaction score core.
// ----------------------------------------------------------------------------
package bisc_pkg;

    localparam int SCORE_W     = 56;
    localparam int OPC_W       = 2;
    localparam int IDX_IN_W    = 4;
    localparam int IN_VAL_W    = 16;
    localparam int AW_W        = 5;
    localparam int AW_RESET    = 16;
    localparam int DRAIN_CYC   = 3;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_SEL_BIT = 2;

    typedef enum logic [OPC_W-1:0] {
        OP_WR_COEF = 2'd0,
        OP_WR_VEC  = 2'd1,
        OP_SCORE   = 2'd2
    } t_opcode;

    typedef enum logic {
        REG_ACTIVE_WIDTH = 1'b0
    } t_reg_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SUM,
        ST_DONE
    } t_state;

    // sequencer to cells
    typedef struct packed {
        logic clear;
        logic step;
    } t_seq;

    // write strobes to cells
    typedef struct packed {
        logic coef_we;
        logic vec_we;
    } t_wr;

    // sequencer status to top
    typedef struct packed {
        logic busy;
        logic capture;
        logic valid;
    } t_stat;

endpackage : bisc_pkg
`default_nettype wire

@@ src/bilinear_interaction_score_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_interaction_score_core
// Bilinear score b^T C p over a chain of MAX_WIDTH row cells.
// ----------------------------------------------------------------------------
// Coefficient and feature writes (opcodes 0 and 1) never raise busy. A score
// (opcode 2) keeps busy high and presents o_score with o_score_valid in the
// last busy cycle. The prey vector rotates once around the cell ring, the
// multiply pipeline drains, and then the per-row sums settle down the adder
// chain. The score strobe lasts one cycle and cannot be stalled. The user
// must write active_width only while busy is low; the block does not enforce
// this. Values above MAX_WIDTH act as MAX_WIDTH.
// ----------------------------------------------------------------------------
module bilinear_interaction_score_core
    import bisc_pkg::*;
#(
    parameter int MAX_WIDTH  = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [OPC_W-1:0]              i_opcode,
    input  wire logic [IDX_IN_W-1:0]           i_row_index,
    input  wire logic [IDX_IN_W-1:0]           i_col_index,
    input  wire logic signed [IN_VAL_W-1:0]    i_first_value,
    input  wire logic signed [IN_VAL_W-1:0]    i_second_value,
    output logic                               o_score_valid,
    output logic signed [SCORE_W-1:0]          o_score,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [APB_ADDR_W-1:0]         paddr,
    input  wire logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]              prdata,
    output logic                               pready
);

    localparam int N  = MAX_WIDTH;
    localparam int VB = VALUE_BITS;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int WW = $clog2(N + 1);
    localparam int XW = 7;

    logic [AW_W-1:0]          r_aw;
    logic [SCORE_W-1:0]       r_score;
    logic                     accept;
    logic                     go;
    logic                     col_ok;
    logic [XW-1:0]            aw_x;
    logic [WW-1:0]            w_eff;
    logic [IW-1:0]            col_addr;
    logic signed [VB-1:0]     first_v;
    logic signed [VB-1:0]     second_v;
    t_wr                      wr;
    t_seq                     seq;
    t_stat                    stat;

    logic signed [VB-1:0]     p_ring   [N];
    logic [IW-1:0]            idx_ring [N];
    logic [SCORE_W-1:0]       sum_ring [N];

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw <= AW_W'(AW_RESET);
        end else if (psel && penable && pwrite
                     && (paddr[REG_SEL_BIT] == REG_ACTIVE_WIDTH)) begin
            r_aw <= pwdata[AW_W-1:0];
        end
    end

    assign prdata = (paddr[REG_SEL_BIT] == REG_ACTIVE_WIDTH)
                  ? APB_DATA_W'(r_aw) : '0;

    assign aw_x  = XW'(r_aw);
    assign w_eff = (aw_x > XW'(N)) ? WW'(N) : WW'(aw_x);

    // command decode
    assign accept   = start && !busy;
    assign col_ok   = (XW'(i_col_index) < XW'(N));
    assign col_addr = IW'(i_col_index);
    assign first_v  = VB'(i_first_value);
    assign second_v = VB'(i_second_value);

    always_comb begin
        wr.coef_we = 1'b0;
        wr.vec_we  = 1'b0;
        go         = 1'b0;
        case (i_opcode)
            OP_WR_COEF: wr.coef_we = accept && col_ok;
            OP_WR_VEC:  wr.vec_we  = accept;
            OP_SCORE:   go         = accept;
            default:    go         = 1'b0;
        endcase
    end

    bisc_ctrl #(
        .N (N)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .o_seq   (seq),
        .o_stat  (stat)
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        bisc_cell #(
            .N       (N),
            .VB      (VB),
            .IW      (IW),
            .WW      (WW),
            .CELL_ID (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_seq      (seq),
            .i_wr       (wr),
            .i_row      (i_row_index),
            .i_col      (col_addr),
            .i_first    (first_v),
            .i_second   (second_v),
            .i_w_eff    (w_eff),
            .i_p_next   (p_ring[(g + 1) % N]),
            .i_idx_next (idx_ring[(g + 1) % N]),
            .o_p        (p_ring[g]),
            .o_idx      (idx_ring[g]),
            .i_sum      ((g == 0) ? {SCORE_W{1'b0}} : sum_ring[(g + N - 1) % N]),
            .o_sum      (sum_ring[g])
        );
    end

    // last computed score
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= '0;
        end else if (stat.capture) begin
            r_score <= sum_ring[N-1];
        end
    end

    assign busy          = stat.busy;
    assign o_score_valid = stat.valid;
    assign o_score       = r_score;

endmodule : bilinear_interaction_score_core
`default_nettype wire

@@ src/bisc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bisc_ctrl
// Score sequencer: ring rotation, pipeline drain, sum chain settle, strobe.
// ----------------------------------------------------------------------------
module bisc_ctrl
    import bisc_pkg::*;
#(
    parameter int N = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_go,
    output t_seq       o_seq,
    output t_stat      o_stat
);

    localparam int CW = $clog2(N + 2);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CW'(1);
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_go) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == CW'(N - 1)) begin
                    n_state = ST_DRAIN;
                    n_cnt   = '0;
                end
            end
            ST_DRAIN: begin
                if (r_cnt == CW'(DRAIN_CYC - 1)) begin
                    n_state = ST_SUM;
                    n_cnt   = '0;
                end
            end
            ST_SUM: begin
                if (r_cnt == CW'(N)) begin
                    n_state = ST_DONE;
                    n_cnt   = '0;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_seq.clear    = 1'b0;
        o_seq.step     = 1'b0;
        o_stat.busy    = 1'b1;
        o_stat.capture = 1'b0;
        o_stat.valid   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stat.busy = 1'b0;
                o_seq.clear = i_go;
            end
            ST_RUN: begin
                o_seq.step = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_SUM: begin
                o_stat.capture = (r_cnt == CW'(N));
            end
            ST_DONE: begin
                o_stat.valid = 1'b1;
            end
            default: begin
                o_stat.busy = 1'b0;
            end
        endcase
    end

endmodule : bisc_ctrl
`default_nettype wire

@@ src/bisc_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bisc_cell
// One row cell: bait element, prey ring slot, coefficient row, row
// accumulator and one stage of the sum chain.
// ----------------------------------------------------------------------------
module bisc_cell
    import bisc_pkg::*;
#(
    parameter int N       = 16,
    parameter int VB      = 16,
    parameter int IW      = 4,
    parameter int WW      = 5,
    parameter int CELL_ID = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_seq                  i_seq,
    input  wire t_wr                   i_wr,
    input  wire logic [IDX_IN_W-1:0]   i_row,
    input  wire logic [IW-1:0]         i_col,
    input  wire logic signed [VB-1:0]  i_first,
    input  wire logic signed [VB-1:0]  i_second,
    input  wire logic [WW-1:0]         i_w_eff,
    input  wire logic signed [VB-1:0]  i_p_next,
    input  wire logic [IW-1:0]         i_idx_next,
    output logic signed [VB-1:0]       o_p,
    output logic [IW-1:0]              o_idx,
    input  wire logic [SCORE_W-1:0]    i_sum,
    output logic [SCORE_W-1:0]         o_sum
);

    logic signed [VB-1:0]     r_mem [N];
    logic signed [VB-1:0]     r_b;
    logic signed [VB-1:0]     r_p;
    logic [IW-1:0]            r_idx;
    logic signed [VB-1:0]     r_c;
    logic signed [VB-1:0]     r_pa;
    logic signed [2*VB-1:0]   r_bc;
    logic signed [VB-1:0]     r_pb;
    logic signed [3*VB-1:0]   r_t;
    logic [SCORE_W-1:0]       r_acc;
    logic [SCORE_W-1:0]       r_sum;
    logic                     r_va, r_vb, r_vc;
    logic                     row_hit;
    logic                     in_use;

    assign row_hit = (32'(i_row) == CELL_ID);
    assign in_use  = (WW'(CELL_ID) < i_w_eff) && (WW'(r_idx) < i_w_eff);

    // coefficient row
    always_ff @(posedge i_clk) begin
        if (i_wr.coef_we && row_hit) begin
            r_mem[i_col] <= i_first;
        end
        r_c <= r_mem[r_idx];
    end

    // prey ring slot and its home index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= IW'(CELL_ID);
        end else if (i_seq.step) begin
            r_idx <= i_idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seq.step) begin
            r_p <= i_p_next;
        end else if (i_wr.vec_we && row_hit) begin
            r_p <= i_second;
        end
        if (i_wr.vec_we && row_hit) begin
            r_b <= i_first;
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_seq.step && in_use;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // b * c, then * p, then accumulate modulo 2^SCORE_W
    always_ff @(posedge i_clk) begin
        r_pa <= r_p;
        r_bc <= r_b * r_c;
        r_pb <= r_pa;
        r_t  <= r_bc * r_pb;
        if (i_seq.clear) begin
            r_acc <= '0;
        end else if (r_vc) begin
            r_acc <= r_acc + SCORE_W'(r_t);
        end
        r_sum <= i_sum + r_acc;
    end

    assign o_p   = r_p;
    assign o_idx = r_idx;
    assign o_sum = r_sum;

endmodule : bisc_cell
`default_nettype wire

@@ src/bisc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bisc_checker
// Port-level checks of the command and score channels and of APB pready.
// ----------------------------------------------------------------------------
module bisc_checker
    import bisc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [OPC_W-1:0]   i_opcode,
    input  wire logic               o_score_valid,
    input  wire logic               pready
);

    logic score_xfer;
    logic other_xfer;

    assign score_xfer = start && !busy && (i_opcode == OP_SCORE);
    assign other_xfer = start && !busy && (i_opcode != OP_SCORE);

    a_score_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        score_xfer |=> busy && !o_score_valid)
        else $error("score transfer did not raise busy");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        other_xfer |=> !busy && !o_score_valid)
        else $error("write transfer disturbed the sequencer");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_score_valid |-> busy)
        else $error("score strobe outside a busy window");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_score_valid |=> !o_score_valid && !busy)
        else $error("score strobe longer than one cycle");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule : bisc_checker

bind bilinear_interaction_score_core bisc_checker u_bisc_checker (.*);
`default_nettype wire
